FILE: hw/rtl/glyph_pixel_renderer_core_assert.svh
// Assertion macros for the glyph pixel renderer.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef GLYPH_PIXEL_RENDERER_CORE_ASSERT_SVH
`define GLYPH_PIXEL_RENDERER_CORE_ASSERT_SVH

// Checked property, masked while reset is high
`define GPR_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("gpr assertion failed");

// Checked property that also holds across reset
`define GPR_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("gpr assertion failed");

`endif

FILE: hw/rtl/gpr_pkg.sv
// Package for the glyph pixel renderer: geometry constants, command and
// register codes, the 5x7 column font and its lookup function. No dependencies.
package gpr_pkg;

   // Screen geometry in character cells and pixels
   localparam int MAX_COL     = 20;
   localparam int MAX_ROW     = 19;
   localparam int CELL_WIDTH  = 6;
   localparam int CELL_HEIGHT = 8;

   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 7;
   localparam int FIRST_CODE  = 32;
   localparam int GLYPH_COUNT = 96;

   // Field widths
   localparam int CODE_W   = 8;
   localparam int COLOR_W  = 16;
   localparam int CURSOR_W = 5;
   localparam int PIX_X_W  = 7;
   localparam int PIX_Y_W  = 8;
   localparam int GCOL_W   = 3;
   localparam int GROW_W   = 3;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_BACKGROUND = 1'b0;

   // Command codes
   localparam logic CMD_GLYPH  = 1'b0;
   localparam logic CMD_CURSOR = 1'b1;

   // One glyph: five columns, bit r of a column is glyph row r
   typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_type;

   // Font, codes 32..127, column bytes packed first column in the top byte
   localparam logic [39:0] FONT_TABLE [GLYPH_COUNT] = '{
      40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
      40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
      40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
      40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
      40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
      40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
      40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
      40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
      40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
      40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_41_51_32,
      40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
      40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
      40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
      40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
      40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_00_7F_41_41,
      40'h02_04_08_10_20, 40'h41_41_7F_00_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
      40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
      40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
      40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h00_7F_10_28_44,
      40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
      40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
      40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
      40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
      40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h08_08_2A_1C_08, 40'h08_1C_2A_08_08
   };

   // Glyph for a character code; codes outside the font give a blank glyph
   function automatic glyph_type glyph_lookup(input logic [CODE_W-1:0] code);
      logic [39:0] raw;
      logic [6:0]  idx;
      glyph_type   bits;
      raw = '0;
      idx = '0;
      if (!code[7] && (code[6:0] >= 7'(FIRST_CODE))) begin
         idx = code[6:0] - 7'(FIRST_CODE);
         raw = FONT_TABLE[idx];
      end
      for (int c = 0; c < GLYPH_COLS; c++) begin
         bits[c] = raw[(GLYPH_COLS-1-c)*8 +: GLYPH_ROWS];
      end
      return bits;
   endfunction

endpackage

FILE: hw/rtl/gpr_if.sv
// Valid/ready channel interfaces for the glyph pixel renderer words.
// Depends on gpr_pkg for field widths.
interface gpr_req_if;
   logic                            valid;
   logic                            ready;
   logic                            cmd;
   logic [gpr_pkg::CODE_W-1:0]      char_code;
   logic [gpr_pkg::COLOR_W-1:0]     fg_color;
   logic [gpr_pkg::CURSOR_W-1:0]    cursor_col;
   logic [gpr_pkg::CURSOR_W-1:0]    cursor_row;

   modport source (output valid, cmd, char_code, fg_color, cursor_col, cursor_row,
                   input ready);
   modport sink   (input valid, cmd, char_code, fg_color, cursor_col, cursor_row,
                   output ready);
endinterface

interface gpr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [gpr_pkg::PIX_X_W-1:0]     pixel_x;
   logic [gpr_pkg::PIX_Y_W-1:0]     pixel_y;
   logic [gpr_pkg::COLOR_W-1:0]     pixel_color;
   logic                            last;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

FILE: hw/rtl/glyph_pixel_renderer_core.sv
// Glyph pixel renderer top level: font lookup, pixel sequencer, output register,
// APB-style background register. Depends on gpr_pkg, gpr_if.sv and the assert header.
//
// A glyph word produces 35 pixel words, one per cycle while the output is not
// stalled, row by row (7 rows of 5 columns); the rate is set by the single pixel
// counter that walks the glyph. The next word is taken in the cycle the last
// pixel of the current glyph moves into the output register, so glyphs stream
// without gaps. A set-cursor word only moves the cursor and produces nothing. The
// background colour is read as each pixel is formed; write it only while idle.
`include "glyph_pixel_renderer_core_assert.svh"

module glyph_pixel_renderer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   gpr_req_if.sink                              req_bus,
   gpr_rsp_if.source                            rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gpr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [gpr_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [gpr_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   // Control state
   logic                                bg_we;
   logic [gpr_pkg::COLOR_W-1:0]         bg_color_ff, bg_color_in;
   logic [gpr_pkg::CURSOR_W-1:0]        cur_col_ff, cur_col_in;
   logic [gpr_pkg::CURSOR_W-1:0]        cur_row_ff, cur_row_in;
   logic                                busy_ff, busy_in;
   logic [gpr_pkg::GCOL_W-1:0]          gcol_ff, gcol_in;
   logic [gpr_pkg::GROW_W-1:0]          grow_ff, grow_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Glyph payload
   gpr_pkg::glyph_type                  glyph_ff, glyph_in;
   logic [gpr_pkg::COLOR_W-1:0]         fg_ff, fg_in;
   logic [gpr_pkg::PIX_X_W-1:0]         base_x_ff, base_x_in;
   logic [gpr_pkg::PIX_Y_W-1:0]         base_y_ff, base_y_in;

   // Output payload
   logic [gpr_pkg::PIX_X_W-1:0]         pix_x_ff, pix_x_in;
   logic [gpr_pkg::PIX_Y_W-1:0]         pix_y_ff, pix_y_in;
   logic [gpr_pkg::COLOR_W-1:0]         pix_color_ff, pix_color_in;
   logic                                pix_last_ff, pix_last_in;

   logic                                out_load;
   logic                                last_pix;
   logic                                req_ready;
   logic                                req_acc;
   logic                                glyph_acc;
   logic                                cursor_acc;
   logic [7:0]                          base_x_full;
   logic [5:0]                          col_inc;
   logic [5:0]                          row_inc;
   logic [5:0]                          row_next;

   // Configuration port
   assign csr_pready = 1'b1;
   assign bg_we = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                  (csr_paddr[gpr_pkg::CSR_ADDR_W-1] == gpr_pkg::CSR_IDX_BACKGROUND);
   assign bg_color_in = bg_we ? csr_pwdata[gpr_pkg::COLOR_W-1:0] : bg_color_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[gpr_pkg::CSR_ADDR_W-1] == gpr_pkg::CSR_IDX_BACKGROUND) begin
         csr_prdata = {{(gpr_pkg::CSR_DATA_W-gpr_pkg::COLOR_W){1'b0}}, bg_color_ff};
      end
   end

   // Handshake and sequencing
   assign out_load   = busy_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign last_pix   = (grow_ff == gpr_pkg::GROW_W'(gpr_pkg::GLYPH_ROWS-1)) &&
                       (gcol_ff == gpr_pkg::GCOL_W'(gpr_pkg::GLYPH_COLS-1));
   assign req_ready  = !busy_ff || (out_load && last_pix);
   assign req_bus.ready = req_ready;
   assign req_acc    = req_bus.valid && req_ready;
   assign glyph_acc  = req_acc && (req_bus.cmd == gpr_pkg::CMD_GLYPH);
   assign cursor_acc = req_acc && (req_bus.cmd == gpr_pkg::CMD_CURSOR);

   // Cell origin of the glyph and cursor advance, both taken at acceptance
   assign base_x_full = {3'b000, cur_col_ff} * 8'(gpr_pkg::CELL_WIDTH);
   assign base_x_in   = base_x_full[gpr_pkg::PIX_X_W-1:0];
   assign base_y_in   = {3'b000, cur_row_ff} * 8'(gpr_pkg::CELL_HEIGHT);
   assign glyph_in    = gpr_pkg::glyph_lookup(req_bus.char_code);
   assign fg_in       = req_bus.fg_color;
   assign col_inc     = {1'b0, cur_col_ff} + 6'd1;
   assign row_inc     = {1'b0, cur_row_ff} + 6'd1;

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      row_next   = {1'b0, cur_row_ff};
      if (cursor_acc) begin
         cur_col_in = req_bus.cursor_col;
         cur_row_in = req_bus.cursor_row;
      end else if (glyph_acc) begin
         cur_col_in = col_inc[gpr_pkg::CURSOR_W-1:0];
         if (col_inc > 6'(gpr_pkg::MAX_COL)) begin
            cur_col_in = gpr_pkg::CURSOR_W'(1);
            row_next   = row_inc;
         end
         if (row_next > 6'(gpr_pkg::MAX_ROW)) begin
            row_next = 6'd1;
         end
         cur_row_in = row_next[gpr_pkg::CURSOR_W-1:0];
      end
   end

   // Pixel counter: columns within a row, then rows
   always_comb begin
      busy_in = busy_ff;
      gcol_in = gcol_ff;
      grow_in = grow_ff;
      if (glyph_acc) begin
         busy_in = 1'b1;
         gcol_in = '0;
         grow_in = '0;
      end else if (out_load) begin
         if (last_pix) begin
            busy_in = 1'b0;
         end
         if (gcol_ff == gpr_pkg::GCOL_W'(gpr_pkg::GLYPH_COLS-1)) begin
            gcol_in = '0;
            grow_in = grow_ff + gpr_pkg::GROW_W'(1);
         end else begin
            gcol_in = gcol_ff + gpr_pkg::GCOL_W'(1);
         end
      end
   end

   // Pixel formation into the output register
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);

   always_comb begin
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      pix_color_in = pix_color_ff;
      pix_last_in  = pix_last_ff;
      if (out_load) begin
         pix_x_in     = base_x_ff + {4'b0000, gcol_ff};
         pix_y_in     = base_y_ff + {5'b00000, grow_ff};
         pix_color_in = glyph_ff[gcol_ff][grow_ff] ? fg_ff : bg_color_ff;
         pix_last_in  = last_pix;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_x     = pix_x_ff;
   assign rsp_bus.pixel_y     = pix_y_ff;
   assign rsp_bus.pixel_color = pix_color_ff;
   assign rsp_bus.last        = pix_last_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bg_color_ff  <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         busy_ff      <= 1'b0;
         gcol_ff      <= '0;
         grow_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bg_color_ff  <= bg_color_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         busy_ff      <= busy_in;
         gcol_ff      <= gcol_in;
         grow_ff      <= grow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (glyph_acc) begin
         glyph_ff  <= glyph_in;
         fg_ff     <= fg_in;
         base_x_ff <= base_x_in;
         base_y_ff <= base_y_in;
      end
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      pix_color_ff <= pix_color_in;
      pix_last_ff  <= pix_last_in;
   end

   // Checks
   `GPR_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy_ff && !rsp_valid_ff))
   `GPR_ASSERT(a_glyph_starts, glyph_acc |=> (busy_ff && gcol_ff == '0 && grow_ff == '0))
   `GPR_ASSERT(a_busy_until_last, (busy_ff && !(out_load && last_pix)) |=> busy_ff)
   `GPR_ASSERT(a_last_on_bottom_row, (rsp_valid_ff && pix_last_ff) |-> (pix_y_ff[2:0] == 3'd6))

endmodule

FILE: tb/tb_glyph_pixel_renderer_core.sv
// Self-checking testbench for glyph_pixel_renderer_core: drives text and cursor
// words, predicts every pixel word from its own font copy and cursor state.
// Depends on gpr_pkg, gpr_if.sv and the RTL of the core.
module tb_glyph_pixel_renderer_core;

   // Text-mode geometry and font as the predictor sees it
   localparam int LAST_COL   = 20;
   localparam int LAST_ROW   = 19;
   localparam int CELL_W     = 6;
   localparam int CELL_H     = 8;
   localparam int FONT_FIRST = 32;
   localparam int FONT_SIZE  = 96;
   localparam int GLYPH_W    = 5;
   localparam int GLYPH_H    = 7;

   // Register map
   localparam logic [gpr_pkg::CSR_ADDR_W-1:0] BG_ADDR =
      gpr_pkg::CSR_ADDR_W'(4 * gpr_pkg::CSR_IDX_BACKGROUND);
   localparam int UNMAPPED_IDX = 1;
   localparam logic [gpr_pkg::CSR_ADDR_W-1:0] UNMAPPED_ADDR =
      gpr_pkg::CSR_ADDR_W'(4 * UNMAPPED_IDX);

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_PHASES  = 3;
   localparam int PHASE_WORDS    = 45;
   localparam int STREAM_WORDS   = 20;

   // Column-major 5x7 font, first column in the top byte, bit r = glyph row r
   localparam logic [39:0] GLYPH_FONT [FONT_SIZE] = '{
      40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
      40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
      40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
      40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
      40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
      40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
      40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
      40'h00_08_14_22_41, 40'h14_14_14_14_14, 40'h41_22_14_08_00, 40'h02_01_51_09_06,
      40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
      40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_01_01, 40'h3E_41_41_51_32,
      40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
      40'h7F_40_40_40_40, 40'h7F_02_04_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
      40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
      40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F,
      40'h63_14_08_14_63, 40'h03_04_78_04_03, 40'h61_51_49_45_43, 40'h00_00_7F_41_41,
      40'h02_04_08_10_20, 40'h41_41_7F_00_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
      40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
      40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h08_14_54_54_3C,
      40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h00_7F_10_28_44,
      40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
      40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
      40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
      40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
      40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h08_08_2A_1C_08, 40'h08_1C_2A_08_08
   };

   typedef struct packed {
      logic                           cmd;
      logic [gpr_pkg::CODE_W-1:0]     code;
      logic [gpr_pkg::COLOR_W-1:0]    fg;
      logic [gpr_pkg::CURSOR_W-1:0]   col;
      logic [gpr_pkg::CURSOR_W-1:0]   row;
   } text_word_type;

   typedef struct packed {
      logic [gpr_pkg::PIX_X_W-1:0]    x;
      logic [gpr_pkg::PIX_Y_W-1:0]    y;
      logic [gpr_pkg::COLOR_W-1:0]    color;
      logic                           last;
   } pixel_word_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [gpr_pkg::CSR_ADDR_W-1:0]    csr_paddr;
   logic [gpr_pkg::CSR_DATA_W-1:0]    csr_pwdata;
   logic [gpr_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                              csr_pready;

   gpr_req_if req_bus ();
   gpr_rsp_if rsp_bus ();

   // Predictor state: cursor and background colour
   logic [gpr_pkg::CURSOR_W-1:0]      cursor_col;
   logic [gpr_pkg::CURSOR_W-1:0]      cursor_row;
   logic [gpr_pkg::COLOR_W-1:0]       bg_colour;
   pixel_word_type                    pending_pixels [$];

   int                                fail_count;
   int                                quiet_cycles;
   bit                                req_idle_on;
   bit                                rsp_stall_on;

   glyph_pixel_renderer_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Expected pixels of one word, then the cursor step
   task automatic predict_pixels(input text_word_type w);
      logic [39:0]    cols;
      int             base_x;
      int             base_y;
      int             next_col;
      int             next_row;
      pixel_word_type px;
      if (w.cmd == gpr_pkg::CMD_CURSOR) begin
         cursor_col = w.col;
         cursor_row = w.row;
         return;
      end
      cols = '0;
      if (w.code >= FONT_FIRST && w.code < FONT_FIRST + FONT_SIZE)
         cols = GLYPH_FONT[w.code - FONT_FIRST];
      base_x = cursor_col * CELL_W;
      base_y = cursor_row * CELL_H;
      for (int r = 0; r < GLYPH_H; r++) begin
         for (int c = 0; c < GLYPH_W; c++) begin
            px.x     = gpr_pkg::PIX_X_W'(base_x + c);
            px.y     = gpr_pkg::PIX_Y_W'(base_y + r);
            px.color = cols[(GLYPH_W - 1 - c) * 8 + r] ? w.fg : bg_colour;
            px.last  = (r == GLYPH_H - 1) && (c == GLYPH_W - 1);
            pending_pixels.push_back(px);
         end
      end
      // column wraps to 1 and bumps the row; row wraps to 1
      next_col = cursor_col + 1;
      next_row = cursor_row;
      if (next_col > LAST_COL) begin
         next_col = 1;
         next_row = next_row + 1;
      end
      if (next_row > LAST_ROW)
         next_row = 1;
      cursor_col = gpr_pkg::CURSOR_W'(next_col);
      cursor_row = gpr_pkg::CURSOR_W'(next_row);
   endtask

   // Send one word; valid stays high afterwards so words can stream
   task automatic send_word(input text_word_type w);
      int gap;
      int backlog;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         // sometimes hold the gap until the current glyph is nearly out
         if ($urandom_range(0, 1) == 1) begin
            backlog = $urandom_range(0, 3);
            while (pending_pixels.size() > backlog) @(posedge clock);
         end
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= w.cmd;
      req_bus.char_code  <= w.code;
      req_bus.fg_color   <= w.fg;
      req_bus.cursor_col <= w.col;
      req_bus.cursor_row <= w.row;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_pixels(w);
   endtask

   task automatic send_glyph(input logic [gpr_pkg::CODE_W-1:0] code,
                             input logic [gpr_pkg::COLOR_W-1:0] fg);
      text_word_type w;
      w      = '0;
      w.cmd  = gpr_pkg::CMD_GLYPH;
      w.code = code;
      w.fg   = fg;
      w.col  = gpr_pkg::CURSOR_W'($urandom);
      w.row  = gpr_pkg::CURSOR_W'($urandom);
      send_word(w);
   endtask

   task automatic send_cursor(input logic [gpr_pkg::CURSOR_W-1:0] col,
                              input logic [gpr_pkg::CURSOR_W-1:0] row);
      text_word_type w;
      w      = '0;
      w.cmd  = gpr_pkg::CMD_CURSOR;
      w.code = gpr_pkg::CODE_W'($urandom);
      w.fg   = gpr_pkg::COLOR_W'($urandom);
      w.col  = col;
      w.row  = row;
      send_word(w);
   endtask

   // Mostly printable glyphs at on-screen cursors, with the odd stray code
   function automatic text_word_type random_word();
      text_word_type w;
      w.cmd  = ($urandom_range(0, 6) == 0) ? gpr_pkg::CMD_CURSOR : gpr_pkg::CMD_GLYPH;
      w.code = ($urandom_range(0, 7) == 0) ? gpr_pkg::CODE_W'($urandom_range(0, 255))
                                            : gpr_pkg::CODE_W'($urandom_range(32, 127));
      w.fg   = gpr_pkg::COLOR_W'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         w.col = gpr_pkg::CURSOR_W'($urandom);
         w.row = gpr_pkg::CURSOR_W'($urandom);
      end else begin
         w.col = gpr_pkg::CURSOR_W'($urandom_range(0, LAST_COL));
         w.row = gpr_pkg::CURSOR_W'($urandom_range(0, LAST_ROW));
      end
      return w;
   endfunction

   // Stop sending and wait for every pixel, then let a cursor word settle
   task automatic wait_for_pixels();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup phase, access phase, then idle before the next transfer
   task automatic csr_write(input logic [gpr_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [gpr_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == BG_ADDR)
         bg_colour = data[gpr_pkg::COLOR_W-1:0];
      @(posedge clock);
   endtask

   task automatic csr_check_background();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= BG_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[gpr_pkg::COLOR_W-1:0] !== bg_colour) begin
         $display("%0t: background readback expected %h actual %h", $time, bg_colour,
                  csr_prdata[gpr_pkg::COLOR_W-1:0]);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Reset value, both extremes, and a write to an unmapped address
   task automatic test_background_register();
      csr_check_background();
      csr_write(BG_ADDR, 32'h0000_FFFF);
      csr_check_background();
      csr_write(UNMAPPED_ADDR, 32'h0000_1234);
      csr_check_background();
   endtask

   // Codes either side of the font, first and last glyph, colour extremes
   task automatic test_font_edges();
      send_cursor('0, '0);
      send_glyph(8'd0, 16'h0000);
      send_glyph(8'd31, 16'hFFFF);
      send_glyph(8'd32, 16'hFFFF);
      send_glyph(8'd33, 16'h0000);
      send_glyph(8'd65, 16'hA5A5);
      send_glyph(8'd126, 16'h5A5A);
      send_glyph(8'd127, 16'hFFFF);
      send_glyph(8'd128, 16'h0000);
      send_glyph(8'd255, 16'hFFFF);
      wait_for_pixels();
   endtask

   // Column and row wrap, cursor beyond the screen, cursor over cursor
   task automatic test_cursor_edges();
      csr_write(BG_ADDR, 32'h0000_0000);
      send_cursor(5'd20, 5'd19);
      send_glyph(8'd72, 16'hFFFF);
      send_cursor(5'd20, 5'd5);
      send_glyph(8'd87, 16'h07E0);
      send_cursor(5'd5, 5'd19);
      send_glyph(8'd35, 16'hF800);
      send_cursor(5'd31, 5'd31);
      send_glyph(8'd64, 16'h001F);
      send_cursor(5'd21, 5'd20);
      send_cursor(5'd0, 5'd0);
      send_glyph(8'd48, 16'hFFFF);
      wait_for_pixels();
   endtask

   // Random text under several background colours
   task automatic test_random_text();
      logic [gpr_pkg::COLOR_W-1:0] shades [RANDOM_PHASES];
      shades[0] = gpr_pkg::COLOR_W'($urandom);
      shades[1] = 16'hFFFF;
      shades[2] = 16'h0000;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         csr_write(BG_ADDR, {16'h0000, shades[p]});
         csr_check_background();
         for (int i = 0; i < PHASE_WORDS; i++)
            send_word(random_word());
         wait_for_pixels();
      end
   endtask

   // Back-to-back glyphs with no idling on either side
   task automatic test_streaming();
      text_word_type w;
      req_idle_on  = 1'b0;
      rsp_stall_on = 1'b0;
      csr_write(BG_ADDR, {16'h0000, gpr_pkg::COLOR_W'($urandom)});
      for (int i = 0; i < STREAM_WORDS; i++) begin
         w     = random_word();
         w.cmd = gpr_pkg::CMD_GLYPH;
         send_word(w);
      end
      wait_for_pixels();
   endtask

   // Result sink: random stall bursts while enabled
   initial begin
      forever begin
         if (rsp_stall_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Compare each pixel word with the oldest expectation
   always @(posedge clock) begin : check_pixels
      pixel_word_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected pixel word x=%h y=%h colour=%h last=%b", $time,
                     rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.pixel_color, rsp_bus.last);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.pixel_x !== want.x) begin
               $display("%0t: pixel_x expected %h actual %h", $time, want.x, rsp_bus.pixel_x);
               fail_count++;
            end
            if (rsp_bus.pixel_y !== want.y) begin
               $display("%0t: pixel_y expected %h actual %h", $time, want.y, rsp_bus.pixel_y);
               fail_count++;
            end
            if (rsp_bus.pixel_color !== want.color) begin
               $display("%0t: pixel_color expected %h actual %h", $time, want.color,
                        rsp_bus.pixel_color);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      fail_count   = 0;
      req_idle_on  = 1'b1;
      rsp_stall_on = 1'b1;
      cursor_col   = '0;
      cursor_row   = '0;
      bg_colour    = '0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= gpr_pkg::CMD_GLYPH;
      req_bus.char_code  <= '0;
      req_bus.fg_color   <= '0;
      req_bus.cursor_col <= '0;
      req_bus.cursor_row <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_background_register();
      test_font_edges();
      test_cursor_edges();
      test_random_text();
      test_streaming();

      wait_for_pixels();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/gpr_pkg.sv
hw/rtl/gpr_if.sv
hw/rtl/glyph_pixel_renderer_core.sv
tb/tb_glyph_pixel_renderer_core.sv
